// File: design/pte_pkg.sv
// Package for the periodic timer expiry block: payload structs, codes, constants
// and the command/status types between controller and datapath.
// No dependencies.
package pte_pkg;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  // 2^32 modulo 1e9, used to fold the high word when splitting at 1e9.
  localparam logic [28:0] NS_WRAP    = 29'd294967296;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_READ  = 2'd1,
    OP_ARM   = 2'd2,
    OP_SPARE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_WOULDBLOCK = 2'd1,
    ST_NOTARMED   = 2'd2,
    ST_RETRY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_NONBLOCKING = 2'd0,
    REG_REALTIME    = 2'd1,
    REG_OFFSET      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] now_ns;
    logic        absolute;
    logic [31:0] period_sec;
    logic [29:0] period_nsec;
    logic [31:0] initial_sec;
    logic [29:0] initial_nsec;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] expirations;
    logic        readable;
    logic [34:0] period_out_sec;
    logic [29:0] period_out_nsec;
    logic [34:0] remaining_sec;
    logic [29:0] remaining_nsec;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_DIV_PER,
    S_WAIT_PER,
    S_DIV_LEFT,
    S_WAIT_LEFT,
    S_DIV_LATE,
    S_WAIT_LATE,
    S_UPDATE,
    S_OUT
  } state_t;

  // Divider operand selection.
  typedef enum logic [1:0] {
    DSEL_PERIOD,
    DSEL_LEFT,
    DSEL_LATE
  } dsel_t;

  typedef struct packed {
    logic  load_item;
    logic  eval;
    logic  div_start;
    dsel_t div_sel;
    logic  capture_per;
    logic  capture_left;
    logic  capture_late;
    logic  update;
    logic  out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_late;
  } dp_stat_t;

endpackage

// File: design/pte_div.sv
// Radix-2 restoring divider, 64-bit quotient and remainder, one bit per cycle.
// Does not depend on pte_pkg (no types used from it).
module pte_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);

  logic [63:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] shifted;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[63:0], q_r[63]};
    trial    = shifted - {1'b0, dvs_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[63:0];

endmodule

// File: design/pte_ctrl.sv
// Controller state machine: sequences evaluation, up to three divisions and update.
// Depends on pte_pkg.
module pte_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  pte_pkg::dp_stat_t stat,
  output pte_pkg::ctl_cmd_t cmd
);
  import pte_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.div_sel = DSEL_PERIOD;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DIV_PER;
      end
      S_DIV_PER: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_PERIOD;
        state_nxt     = S_WAIT_PER;
      end
      S_WAIT_PER: begin
        if (stat.div_done) begin
          cmd.capture_per = 1'b1;
          state_nxt = S_DIV_LEFT;
        end
      end
      S_DIV_LEFT: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_LEFT;
        state_nxt     = S_WAIT_LEFT;
      end
      S_WAIT_LEFT: begin
        if (stat.div_done) begin
          cmd.capture_left = 1'b1;
          state_nxt = stat.need_late ? S_DIV_LATE : S_UPDATE;
        end
      end
      S_DIV_LATE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_LATE;
        state_nxt     = S_WAIT_LATE;
      end
      S_WAIT_LATE: begin
        if (stat.div_done) begin
          cmd.capture_late = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // Wait until the output register is free.
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

endmodule

// File: design/pte_dp.sv
// Datapath: timer state, configuration registers, operand capture, the split at
// 1e9, the lateness divider and output register. Depends on pte_pkg and pte_div.
module pte_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pte_pkg::ctl_cmd_t  cmd,
  output pte_pkg::dp_stat_t  stat,
  input  pte_pkg::in_item_t  in_data,
  output pte_pkg::out_item_t out_data,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_idx,
  input  logic [63:0]        cfg_wdata,
  output logic [63:0]        cfg_rdata
);
  import pte_pkg::*;

  in_item_t    item_r;
  logic [63:0] deadline_r, deadline_nxt;
  logic [63:0] period_r, period_nxt;
  logic        nonblock_r, realtime_r;
  logic [63:0] offset_r;
  logic        ready_r;
  logic [63:0] left_r, late_r;
  logic [34:0] pq_r, lq_r;
  logic [29:0] pr_r, lr_r;
  logic [63:0] xq_r, xr_r;
  logic [63:0] init_prod_r, per_prod_r;
  out_item_t   out_r;

  logic [63:0] cd_x_r;
  logic [34:0] cd_q_r;
  logic [29:0] cd_rem_r;
  logic        cd_busy_r, cd_done_r;
  logic        cd_start, gd_start;
  logic [63:0] cd_in;
  logic [60:0] cd_prod;
  logic [63:0] cd_fold;
  logic [31:0] cd_low, cd_low_rem;
  logic [2:0]  cd_k;

  logic        div_done;
  logic [63:0] div_q, div_rem;
  logic [63:0] init_v, per_v, at_v;
  logic [1:0]  st;
  logic [63:0] fired;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonblock_r <= 1'b0;
      realtime_r <= 1'b0;
      offset_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NONBLOCKING: nonblock_r <= cfg_wdata[0];
        REG_REALTIME:    realtime_r <= cfg_wdata[0];
        REG_OFFSET:      offset_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NONBLOCKING: cfg_rdata = {63'd0, nonblock_r};
      REG_REALTIME:    cfg_rdata = {63'd0, realtime_r};
      REG_OFFSET:      cfg_rdata = offset_r;
      default:         cfg_rdata = '0;
    endcase
  end

  // Start goes to the 1e9 split for period and time left, else to the divider.
  assign cd_start = cmd.div_start && (cmd.div_sel != DSEL_LATE);
  assign gd_start = cmd.div_start && (cmd.div_sel == DSEL_LATE);
  assign cd_in    = (cmd.div_sel == DSEL_LEFT) ? left_r : period_r;

  // Split at 1e9: since 2^32 = 4e9 + NS_WRAP, each step folds the high word
  // down and adds four per unit of it to the quotient. Once the high word is
  // zero, the low word is below 4.3e9 and a compare chain ends the split.
  assign cd_low  = cd_x_r[31:0];
  assign cd_prod = 61'(cd_x_r[63:32]) * 61'(NS_WRAP);
  assign cd_fold = {3'd0, cd_prod} + {32'd0, cd_low};

  always_comb begin
    if (cd_low >= 32'd4000000000) begin
      cd_k       = 3'd4;
      cd_low_rem = cd_low - 32'd4000000000;
    end else if (cd_low >= 32'd3000000000) begin
      cd_k       = 3'd3;
      cd_low_rem = cd_low - 32'd3000000000;
    end else if (cd_low >= 32'd2000000000) begin
      cd_k       = 3'd2;
      cd_low_rem = cd_low - 32'd2000000000;
    end else if (cd_low >= 32'd1000000000) begin
      cd_k       = 3'd1;
      cd_low_rem = cd_low - 32'd1000000000;
    end else begin
      cd_k       = 3'd0;
      cd_low_rem = cd_low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_busy_r <= 1'b0;
      cd_done_r <= 1'b0;
    end else begin
      cd_done_r <= 1'b0;
      if (cd_start) begin
        cd_busy_r <= 1'b1;
      end else if (cd_busy_r && (cd_x_r[63:32] == '0)) begin
        cd_busy_r <= 1'b0;
        cd_done_r <= 1'b1;
      end
    end
    if (cd_start) begin
      cd_x_r <= cd_in;
      cd_q_r <= '0;
    end else if (cd_busy_r) begin
      if (cd_x_r[63:32] != '0) begin
        cd_x_r <= cd_fold;
        cd_q_r <= cd_q_r + {1'b0, cd_x_r[63:32], 2'b00};
      end else begin
        cd_q_r   <= cd_q_r + {32'd0, cd_k};
        cd_rem_r <= cd_low_rem[29:0];
      end
    end
  end

  // Lateness divided by the period.
  pte_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (gd_start),
    .dividend  (late_r),
    .divisor   (period_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign stat.div_done  = div_done | cd_done_r;
  assign stat.need_late = (item_r.opcode == OP_READ) && ready_r && (period_r != '0);

  // Arm values: products registered in the evaluate step.
  assign init_v = init_prod_r + {34'd0, item_r.initial_nsec};
  assign per_v  = per_prod_r + {34'd0, item_r.period_nsec};
  assign at_v   = realtime_r ? init_v - offset_r : init_v;

  // Capture, evaluate and output register load.
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.eval) begin
      ready_r     <= (deadline_r != '0) && (item_r.now_ns >= deadline_r);
      left_r      <= (deadline_r > item_r.now_ns) ? deadline_r - item_r.now_ns : '0;
      late_r      <= item_r.now_ns - deadline_r;
      init_prod_r <= 64'(item_r.initial_sec * 64'd1000000000);
      per_prod_r  <= 64'(item_r.period_sec * 64'd1000000000);
    end
    if (cmd.capture_per)  begin pq_r <= cd_q_r; pr_r <= cd_rem_r; end
    if (cmd.capture_left) begin lq_r <= cd_q_r; lr_r <= cd_rem_r; end
    if (cmd.capture_late) begin xq_r <= div_q; xr_r <= div_rem; end
    if (cmd.out_load) out_r <= '{st, fired, ready_r, pq_r, pr_r, lq_r, lr_r};
  end

  // Status, expirations and next timer state.
  always_comb begin
    deadline_nxt = deadline_r;
    period_nxt   = period_r;
    st           = ST_OK;
    fired        = '0;
    case (item_r.opcode)
      OP_READ: begin
        if (ready_r) begin
          if (period_r != '0) begin
            fired        = xq_r + 64'd1;
            deadline_nxt = item_r.now_ns + period_r - xr_r;
          end else begin
            fired        = 64'd1;
            deadline_nxt = '0;
          end
        end else if (nonblock_r) st = ST_WOULDBLOCK;
        else if (deadline_r == '0) st = ST_NOTARMED;
        else st = ST_RETRY;
      end
      OP_ARM: begin
        period_nxt = per_v;
        if (init_v == '0) deadline_nxt = '0;
        else if (!item_r.absolute) deadline_nxt = item_r.now_ns + init_v;
        else deadline_nxt = (at_v != '0 && !at_v[63]) ? at_v : 64'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= '0;
      period_r   <= '0;
    end else if (cmd.update) begin
      deadline_r <= deadline_nxt;
      period_r   <= period_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// File: design/periodic_timer_expiry.sv
// Periodic timer expiry block, top level.
// Each item goes through evaluate, splits at 1e9 of period and time left, and update.
// Each split folds the high word until it is zero, then ends with a compare chain; a
// read of an expired periodic timer adds a radix-2 division of lateness by the period.
// One item at a time: the next is taken only after the result is registered.
// Reset (rst_n, synchronous) disarms the timer and clears the configuration.
module periodic_timer_expiry (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pte_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pte_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);
  import pte_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     cfg_wr;

  // Registers at 8-byte spacing because the offset is 64 bits.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  pte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pte_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_wr    (cfg_wr && (cfg_paddr[2:0] == 3'd0) && (cfg_paddr[4:3] != 2'd3)),
    .cfg_idx   (cfg_paddr[4:3]),
    .cfg_wdata (cfg_pwdata),
    .cfg_rdata (cfg_prdata)
  );

endmodule
